### hdl/dltq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared types and constants of the delta-list timeout queue: request and
// status codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package dltq_pkg;

   localparam int DEPTH_DEF       = 16;
   localparam int ID_WIDTH_DEF    = 8;
   localparam int DELTA_WIDTH_DEF = 16;
   localparam int TIMEOUT_WIDTH   = 16;
   localparam int REQ_TYPE_WIDTH  = 2;
   localparam int STATUS_WIDTH    = 3;
   localparam int MAX_RESULTS     = 16;

   typedef enum logic [REQ_TYPE_WIDTH-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_TICK   = 2'd2
   } req_op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STAT_INSERTED  = 3'd0,
      STAT_IGNORED   = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_REMOVED   = 3'd3,
      STAT_NOT_FOUND = 3'd4,
      STAT_EXPIRED   = 3'd5
   } rsp_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_IWALK,
      S_SHUP,
      S_IPUT,
      S_RWALK,
      S_SHDN,
      S_TWALK,
      S_RESP
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic           load;
      logic           ptr_inc;
      logic           ptr_dec;
      logic           ptr_top;
      logic           acc_add;
      logic           mark_ins;
      logic           mark_rem;
      logic           mark_gap;
      logic           wr_shup;
      logic           wr_shdn;
      logic           wr_new;
      logic           wr_head;
      logic           cnt_inc;
      logic           cnt_dec;
      logic           cnt_sub_ptr;
      logic           cnt_sub_gap;
      logic           code_load;
      rsp_status_type code;
      logic           emit_req;
      logic           emit_pend;
      logic           emit_last;
      logic           pend_set;
      logic           pend_clr;
   } dltq_cmd_type;

   // datapath to controller
   typedef struct packed {
      req_op_type op;
      logic       t_zero;
      logic       full;
      logic       cnt_zero;
      logic       at_end;
      logic       next_end;
      logic       ptr_zero;
      logic       walk_le;
      logic       id_match;
      logic       pop_ok;
      logic       shup_last;
      logic       pend;
      logic       rsp_free;
   } dltq_stat_type;

endpackage
`default_nettype wire

### hdl/dltq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dltq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hdl/dltq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer of the timeout queue: walks, shifts and result emission.
// ----------------------------------------------------------------------------
module dltq_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire dltq_pkg::dltq_stat_type stat,
   output dltq_pkg::dltq_cmd_type       cmd
);

   dltq_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dltq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.code  = dltq_pkg::STAT_INSERTED;
      req_stall = (state_ff != dltq_pkg::S_IDLE);
      case (state_ff)
         dltq_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = dltq_pkg::S_DISPATCH;
            end
         end
         dltq_pkg::S_DISPATCH: begin
            case (stat.op)
               dltq_pkg::OP_INSERT: begin
                  if (stat.t_zero) begin
                     cmd.code_load = 1'b1;
                     cmd.code      = dltq_pkg::STAT_IGNORED;
                     state_in      = dltq_pkg::S_RESP;
                  end else if (stat.full) begin
                     cmd.code_load = 1'b1;
                     cmd.code      = dltq_pkg::STAT_FULL;
                     state_in      = dltq_pkg::S_RESP;
                  end else begin
                     state_in = dltq_pkg::S_IWALK;
                  end
               end
               dltq_pkg::OP_REMOVE: begin
                  state_in = dltq_pkg::S_RWALK;
               end
               dltq_pkg::OP_TICK: begin
                  state_in = stat.cnt_zero ? dltq_pkg::S_IDLE : dltq_pkg::S_TWALK;
               end
               default: begin
                  state_in = dltq_pkg::S_IDLE;
               end
            endcase
         end
         dltq_pkg::S_IWALK: begin
            if (stat.at_end) begin
               cmd.mark_ins = 1'b1;
               state_in     = dltq_pkg::S_IPUT;
            end else if (stat.walk_le) begin
               cmd.acc_add = 1'b1;
               cmd.ptr_inc = 1'b1;
            end else begin
               cmd.mark_ins = 1'b1;
               cmd.ptr_top  = 1'b1;
               state_in     = dltq_pkg::S_SHUP;
            end
         end
         dltq_pkg::S_SHUP: begin
            cmd.wr_shup = 1'b1;
            if (stat.shup_last) begin
               state_in = dltq_pkg::S_IPUT;
            end else begin
               cmd.ptr_dec = 1'b1;
            end
         end
         dltq_pkg::S_IPUT: begin
            cmd.wr_new    = 1'b1;
            cmd.cnt_inc   = 1'b1;
            cmd.code_load = 1'b1;
            cmd.code      = dltq_pkg::STAT_INSERTED;
            state_in      = dltq_pkg::S_RESP;
         end
         dltq_pkg::S_RWALK: begin
            if (stat.at_end) begin
               cmd.code_load = 1'b1;
               cmd.code      = dltq_pkg::STAT_NOT_FOUND;
               state_in      = dltq_pkg::S_RESP;
            end else if (stat.id_match) begin
               cmd.mark_rem = 1'b1;
               if (stat.next_end) begin
                  cmd.cnt_dec   = 1'b1;
                  cmd.code_load = 1'b1;
                  cmd.code      = dltq_pkg::STAT_REMOVED;
                  state_in      = dltq_pkg::S_RESP;
               end else begin
                  cmd.ptr_inc = 1'b1;
                  state_in    = dltq_pkg::S_SHDN;
               end
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         dltq_pkg::S_SHDN: begin
            cmd.wr_shdn = 1'b1;
            if (stat.next_end) begin
               cmd.cnt_sub_gap = 1'b1;
               if (stat.op == dltq_pkg::OP_REMOVE) begin
                  cmd.code_load = 1'b1;
                  cmd.code      = dltq_pkg::STAT_REMOVED;
                  state_in      = dltq_pkg::S_RESP;
               end else begin
                  state_in = dltq_pkg::S_IDLE;
               end
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         dltq_pkg::S_TWALK: begin
            if (!stat.pend || stat.rsp_free) begin
               cmd.emit_pend = stat.pend;
               cmd.emit_last = !stat.pop_ok;
               if (stat.pop_ok) begin
                  cmd.pend_set = 1'b1;
                  cmd.ptr_inc  = 1'b1;
               end else begin
                  cmd.pend_clr = 1'b1;
                  if (stat.ptr_zero) begin
                     cmd.wr_head = 1'b1;
                     state_in    = dltq_pkg::S_IDLE;
                  end else if (stat.at_end) begin
                     cmd.cnt_sub_ptr = 1'b1;
                     state_in        = dltq_pkg::S_IDLE;
                  end else begin
                     cmd.mark_gap = 1'b1;
                     state_in     = dltq_pkg::S_SHDN;
                  end
               end
            end
         end
         dltq_pkg::S_RESP: begin
            if (stat.rsp_free) begin
               cmd.emit_req = 1'b1;
               state_in     = dltq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dltq_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### hdl/dltq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dltq_dp
// Datapath of the timeout queue: entry RAM, walk pointer, deadline
// accumulator, entry count and the result register.
// ----------------------------------------------------------------------------
module dltq_dp #(
   parameter int DEPTH       = dltq_pkg::DEPTH_DEF,
   parameter int ID_WIDTH    = dltq_pkg::ID_WIDTH_DEF,
   parameter int DELTA_WIDTH = dltq_pkg::DELTA_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [dltq_pkg::REQ_TYPE_WIDTH-1:0] req_type,
   input  wire logic [ID_WIDTH-1:0]                 req_entry_id,
   input  wire logic [dltq_pkg::TIMEOUT_WIDTH-1:0]  req_timeout_ticks,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [dltq_pkg::STATUS_WIDTH-1:0]        rsp_status,
   output logic [ID_WIDTH-1:0]                      rsp_result_id,
   output logic                                     rsp_last,
   input  wire dltq_pkg::dltq_cmd_type              cmd,
   output dltq_pkg::dltq_stat_type                  stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = DELTA_WIDTH;
   localparam int EW = ID_WIDTH + DELTA_WIDTH;
   localparam int TW = dltq_pkg::TIMEOUT_WIDTH;

   dltq_pkg::req_op_type     op_ff;
   dltq_pkg::rsp_status_type code_ff;
   dltq_pkg::rsp_status_type status_ff;
   logic [ID_WIDTH-1:0]      id_ff, pend_id_ff, rid_ff;
   logic [DW-1:0]            t_ff, acc_ff, nd_ff, carry_ff;
   logic [CW-1:0]            ptr_ff, ptr_in, pos_ff, gap_ff, count_ff;
   logic                     pend_ff, rsp_valid_ff, last_ff;

   logic [DW-1:0]            t_sat;
   logic [EW-1:0]            rd_data, wr_data;
   logic [ID_WIDTH-1:0]      rd_id;
   logic [DW-1:0]            rd_delta, delta_eff, delta_fix, delta_sum;
   logic [DW:0]              walk_sum, carry_sum;
   logic [CW-1:0]            wr_ptr;
   logic                     wr_en, rsp_free;

   // clamp the timeout into the delta range
   generate
      if (DELTA_WIDTH >= TW) begin : g_wide
         assign t_sat = DW'(req_timeout_ticks);
      end else begin : g_narrow
         assign t_sat = (req_timeout_ticks[TW-1:DELTA_WIDTH] != '0) ?
                        {DW{1'b1}} : req_timeout_ticks[DELTA_WIDTH-1:0];
      end
   endgenerate

   assign rd_id     = rd_data[EW-1:DW];
   assign rd_delta  = rd_data[DW-1:0];
   assign walk_sum  = {1'b0, acc_ff} + {1'b0, rd_delta};
   assign carry_sum = {1'b0, rd_delta} + {1'b0, carry_ff};
   assign delta_sum = carry_sum[DW] ? {DW{1'b1}} : carry_sum[DW-1:0];
   assign delta_fix = (rd_delta >= nd_ff) ? (rd_delta - nd_ff) : '0;
   assign delta_eff = (ptr_ff != '0) ? rd_delta :
                      ((rd_delta != '0) ? (rd_delta - DW'(1)) : '0);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat.op        = op_ff;
      stat.t_zero    = (t_ff == '0);
      stat.full      = (count_ff == CW'(DEPTH));
      stat.cnt_zero  = (count_ff == '0);
      stat.at_end    = (ptr_ff == count_ff);
      stat.next_end  = ((ptr_ff + CW'(1)) == count_ff);
      stat.ptr_zero  = (ptr_ff == '0);
      stat.walk_le   = (walk_sum <= {1'b0, t_ff});
      stat.id_match  = (rd_id == id_ff);
      stat.pop_ok    = (ptr_ff != count_ff) && (32'(ptr_ff) < dltq_pkg::MAX_RESULTS) &&
                       (delta_eff == '0);
      stat.shup_last = (ptr_ff == pos_ff);
      stat.pend      = pend_ff;
      stat.rsp_free  = rsp_free;
   end

   // walk pointer; its next value is also the RAM read address
   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.load) begin
         ptr_in = '0;
      end else if (cmd.ptr_inc) begin
         ptr_in = ptr_ff + CW'(1);
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_ff - CW'(1);
      end else if (cmd.ptr_top) begin
         ptr_in = count_ff - CW'(1);
      end
   end

   // one write port shared by the shifts and the entry updates
   always_comb begin
      wr_en   = cmd.wr_shup || cmd.wr_shdn || cmd.wr_new || cmd.wr_head;
      wr_ptr  = '0;
      wr_data = {rd_id, rd_delta};
      if (cmd.wr_shup) begin
         wr_ptr  = ptr_ff + CW'(1);
         wr_data = {rd_id, (ptr_ff == pos_ff) ? delta_fix : rd_delta};
      end else if (cmd.wr_shdn) begin
         wr_ptr  = ptr_ff - gap_ff;
         wr_data = {rd_id, delta_sum};
      end else if (cmd.wr_new) begin
         wr_ptr  = pos_ff;
         wr_data = {id_ff, nd_ff};
      end else if (cmd.wr_head) begin
         wr_ptr  = '0;
         wr_data = {rd_id, delta_eff};
      end
   end

   dltq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr[AW-1:0]),
      .wr_data (wr_data),
      .rd_addr (ptr_in[AW-1:0]),
      .rd_data (rd_data)
   );

   // request and walk registers
   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         op_ff  <= dltq_pkg::req_op_type'(req_type);
         id_ff  <= req_entry_id;
         t_ff   <= t_sat;
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= walk_sum[DW-1:0];
      end
      if (cmd.mark_ins) begin
         pos_ff <= ptr_ff;
         nd_ff  <= t_ff - acc_ff;
      end
      if (cmd.mark_rem) begin
         pos_ff   <= ptr_ff;
         gap_ff   <= CW'(1);
         carry_ff <= rd_delta;
      end else if (cmd.mark_gap) begin
         gap_ff   <= ptr_ff;
         carry_ff <= '0;
      end else if (cmd.wr_shdn) begin
         carry_ff <= '0;
      end
      if (cmd.code_load) begin
         code_ff <= cmd.code;
      end
      if (cmd.pend_set) begin
         pend_id_ff <= rd_id;
      end
   end

   // entry count and pending expiry
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.cnt_dec) begin
            count_ff <= count_ff - CW'(1);
         end else if (cmd.cnt_sub_ptr) begin
            count_ff <= count_ff - ptr_ff;
         end else if (cmd.cnt_sub_gap) begin
            count_ff <= count_ff - gap_ff;
         end
         if (cmd.pend_set) begin
            pend_ff <= 1'b1;
         end else if (cmd.pend_clr) begin
            pend_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_req || cmd.emit_pend) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_req) begin
         status_ff <= code_ff;
         rid_ff    <= id_ff;
         last_ff   <= 1'b1;
      end else if (cmd.emit_pend) begin
         status_ff <= dltq_pkg::STAT_EXPIRED;
         rid_ff    <= pend_id_ff;
         last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_result_id = rid_ff;
   assign rsp_last      = last_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_req || cmd.emit_pend) |-> rsp_free)
      else $error("result emitted over an untaken result");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> (count_ff < CW'(DEPTH)) && (pos_ff <= count_ff))
      else $error("insert into a full queue or past its end");

   a_shdn_gap: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_shdn |-> (gap_ff != '0) && (ptr_ff >= gap_ff) && (ptr_ff < count_ff))
      else $error("shift down outside the queue");

   a_count_drop: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_sub_gap || cmd.cnt_sub_ptr) |=> (count_ff < $past(count_ff)))
      else $error("tick or remove did not shrink the queue");

endmodule
`default_nettype wire

### hdl/delta_list_timeout_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delta_list_timeout_queue_unit
// Timeout queue kept as a delta list in deadline order: insert, remove and
// timer tick requests, with expired ids returned one item at a time.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_type, req_entry_id,
//                                            req_timeout_ticks
//  rsp      out        rsp_valid/rsp_stall   rsp_status, rsp_result_id,
//                                            rsp_last
//
//  Items: one item at a time. The entry RAM does one read and one write a
//  cycle; an insert walks to its position, then shifts the later entries
//  up and writes the new entry, a remove walks to the id, then shifts the
//  later entries down, and a tick walks the expired entries, then shifts
//  the rest down.
//  Reset: synchronous, empties the queue and drops any waiting result; the
//  entry RAM itself is not cleared, only entries below the count are read.
//  Stalls: a held result does not block acceptance of the next item; the
//  block only waits when it has a further result to give.
// ----------------------------------------------------------------------------
module delta_list_timeout_queue_unit #(
   parameter int DEPTH       = dltq_pkg::DEPTH_DEF,
   parameter int ID_WIDTH    = dltq_pkg::ID_WIDTH_DEF,
   parameter int DELTA_WIDTH = dltq_pkg::DELTA_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [dltq_pkg::REQ_TYPE_WIDTH-1:0] req_type,
   input  wire logic [ID_WIDTH-1:0]                 req_entry_id,
   input  wire logic [dltq_pkg::TIMEOUT_WIDTH-1:0]  req_timeout_ticks,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [dltq_pkg::STATUS_WIDTH-1:0]        rsp_status,
   output logic [ID_WIDTH-1:0]                      rsp_result_id,
   output logic                                     rsp_last
);

   // command and status between sequencer and datapath
   dltq_pkg::dltq_cmd_type  cmd;
   dltq_pkg::dltq_stat_type stat;

   // sequencer: takes an item only when idle, then walks and shifts the list
   dltq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: entry RAM, pointers, deadline accumulator and result register
   dltq_dp #(
      .DEPTH       (DEPTH),
      .ID_WIDTH    (ID_WIDTH),
      .DELTA_WIDTH (DELTA_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_entry_id      (req_entry_id),
      .req_timeout_ticks (req_timeout_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_last          (rsp_last),
      .cmd               (cmd),
      .stat              (stat)
   );

endmodule
`default_nettype wire

### tb/timer_queue_sb_pkg.sv
// ----------------------------------------------------------------------------
// timer_queue_sb_pkg
// Scoreboard of the delta-list timeout queue: keeps its own deadline-ordered
// copy of the queue, derives the results of every accepted request and checks
// the results that come out of the block in order.
// ----------------------------------------------------------------------------
package timer_queue_sb_pkg;

   import dltq_pkg::*;

   localparam int unsigned DELTA_MAX = (1 << DELTA_WIDTH_DEF) - 1;

   typedef struct {
      rsp_status_type              status;
      logic [ID_WIDTH_DEF-1:0]     id;
      logic                        last;
   } outcome_type;

   class timer_queue_scoreboard;

      logic [ID_WIDTH_DEF-1:0]    slot_id    [DEPTH_DEF];
      logic [DELTA_WIDTH_DEF-1:0] slot_delta [DEPTH_DEF];
      int unsigned                fill;
      outcome_type                due_outcomes[$];
      int unsigned                errors;
      int unsigned                requests;
      int unsigned                checked;
      int unsigned                expiries;
      int unsigned                rejections;

      function new();
         fill       = 0;
         errors     = 0;
         requests   = 0;
         checked    = 0;
         expiries   = 0;
         rejections = 0;
      endfunction

      function void push_outcome(rsp_status_type st, logic [ID_WIDTH_DEF-1:0] id,
                                 logic last);
         outcome_type o;
         o.status = st;
         o.id     = id;
         o.last   = last;
         due_outcomes.push_back(o);
      endfunction

      // place after every entry whose deadline is not later, trim the successor
      function rsp_status_type insert_entry(logic [ID_WIDTH_DEF-1:0] id,
                                            logic [TIMEOUT_WIDTH-1:0] ticks);
         int unsigned pos;
         int unsigned acc;
         int unsigned nd;
         int unsigned j;
         if (ticks == 0)
            return STAT_IGNORED;
         if (fill >= DEPTH_DEF)
            return STAT_FULL;
         pos = 0;
         acc = 0;
         while (pos < fill && acc + slot_delta[pos] <= ticks) begin
            acc += slot_delta[pos];
            pos++;
         end
         nd = ticks - acc;
         for (j = fill; j > pos; j--) begin
            slot_id[j]    = slot_id[j-1];
            slot_delta[j] = slot_delta[j-1];
         end
         slot_id[pos]    = id;
         slot_delta[pos] = DELTA_WIDTH_DEF'(nd);
         fill++;
         if (pos + 1 < fill)
            slot_delta[pos+1] = (slot_delta[pos+1] >= nd) ?
                                DELTA_WIDTH_DEF'(slot_delta[pos+1] - nd) : '0;
         return STAT_INSERTED;
      endfunction

      // hand the removed delta on to the successor
      function rsp_status_type remove_entry(logic [ID_WIDTH_DEF-1:0] id);
         int unsigned pos;
         int unsigned sum;
         int unsigned j;
         pos = 0;
         while (pos < fill && slot_id[pos] != id)
            pos++;
         if (pos >= fill)
            return STAT_NOT_FOUND;
         if (pos + 1 < fill) begin
            sum = slot_delta[pos+1] + slot_delta[pos];
            slot_delta[pos+1] = DELTA_WIDTH_DEF'((sum > DELTA_MAX) ? DELTA_MAX : sum);
         end
         for (j = pos; j + 1 < fill; j++) begin
            slot_id[j]    = slot_id[j+1];
            slot_delta[j] = slot_delta[j+1];
         end
         fill--;
         return STAT_REMOVED;
      endfunction

      function void advance_tick();
         int unsigned n;
         int unsigned j;
         if (fill == 0)
            return;
         if (slot_delta[0] != 0)
            slot_delta[0]--;
         n = 0;
         while (n < fill && n < MAX_RESULTS && slot_delta[n] == 0)
            n++;
         for (j = 0; j < n; j++)
            push_outcome(STAT_EXPIRED, slot_id[j], j == n - 1);
         for (j = 0; j + n < fill; j++) begin
            slot_id[j]    = slot_id[j+n];
            slot_delta[j] = slot_delta[j+n];
         end
         fill -= n;
      endfunction

      function void note_request(logic [REQ_TYPE_WIDTH-1:0] kind,
                                 logic [ID_WIDTH_DEF-1:0] id,
                                 logic [TIMEOUT_WIDTH-1:0] ticks);
         requests++;
         case (kind)
            OP_INSERT: push_outcome(insert_entry(id, ticks), id, 1'b1);
            OP_REMOVE: push_outcome(remove_entry(id), id, 1'b1);
            OP_TICK:   advance_tick();
            default:   ;
         endcase
      endfunction

      function void check_outcome(logic [STATUS_WIDTH-1:0] status,
                                  logic [ID_WIDTH_DEF-1:0] id, logic last);
         outcome_type want;
         checked++;
         if (due_outcomes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: status %0d id 0x%02h last %0d",
                        status, id, last);
            return;
         end
         want = due_outcomes.pop_front();
         if (want.status == STAT_EXPIRED)
            expiries++;
         if (want.status == STAT_FULL)
            rejections++;
         if (status !== want.status || id !== want.id || last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display({"result mismatch: expected status %0d id 0x%02h last %0d,",
                         " got status %0d id 0x%02h last %0d"},
                        want.status, want.id, want.last, status, id, last);
         end
      endfunction

      function int pending();
         return due_outcomes.size();
      endfunction

      // id of a random queued entry, or any id when the queue is empty
      function logic [ID_WIDTH_DEF-1:0] queued_id();
         if (fill == 0)
            return ID_WIDTH_DEF'($urandom);
         return slot_id[$urandom_range(0, fill - 1)];
      endfunction

   endclass

endpackage

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the delta-list timeout queue: a directed opening
// (empty queue, zero timeouts, equal deadlines, duplicate ids, a full queue
// and a tick that expires every entry at once), then random request bursts
// with random gaps while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import dltq_pkg::*;
   import timer_queue_sb_pkg::*;

   // request code the block must ignore
   localparam logic [REQ_TYPE_WIDTH-1:0] OP_UNUSED = 2'd3;

   // result-side stall patterns
   localparam int STALL_NONE   = 0;
   localparam int STALL_RANDOM = 1;
   localparam int STALL_RUNS   = 2;

   localparam int RANDOM_ITEMS = 250;
   localparam int DRAIN_CYCLES = 120;

   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_stall;
   logic [REQ_TYPE_WIDTH-1:0] req_type          = OP_TICK;
   logic [ID_WIDTH_DEF-1:0]   req_entry_id      = '0;
   logic [TIMEOUT_WIDTH-1:0]  req_timeout_ticks = '0;
   logic                      rsp_valid;
   logic                      rsp_stall         = 1'b0;
   logic [STATUS_WIDTH-1:0]   rsp_status;
   logic [ID_WIDTH_DEF-1:0]   rsp_result_id;
   logic                      rsp_last;

   timer_queue_scoreboard sb = new();

   delta_list_timeout_queue_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_entry_id      (req_entry_id),
      .req_timeout_ticks (req_timeout_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Present one item and hold it until the block takes it; valid stays high
   // afterwards so a following item goes out back to back.
   task automatic send_request(input logic [REQ_TYPE_WIDTH-1:0] kind,
                               input logic [ID_WIDTH_DEF-1:0] id,
                               input logic [TIMEOUT_WIDTH-1:0] ticks);
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_entry_id      <= id;
      req_timeout_ticks <= ticks;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      sb.note_request(kind, id, ticks);
   endtask

   // Drop valid for a gap; a zero gap leaves valid alone so it is never
   // lowered and raised in the same step.
   task automatic hold_off(input int cycles);
      if (cycles == 0)
         return;
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Result side: check every accepted result, then pick the next stall
   // value. The pattern switches at random between no stall, random stall
   // and long stall runs.
   int stall_mode   = STALL_NONE;
   int mode_left    = 0;
   int run_left     = 0;
   bit stall_run_on = 1'b0;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_outcome(rsp_status, rsp_result_id, rsp_last);

      if (mode_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end

      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: begin
            if (run_left == 0) begin
               stall_run_on = !stall_run_on;
               run_left     = $urandom_range(1, 12);
            end
            run_left--;
            rsp_stall <= stall_run_on;
         end
      endcase
   end

   initial begin
      int                       counted;
      int                       burst;
      int                       roll;
      logic [REQ_TYPE_WIDTH-1:0] kind;
      logic [ID_WIDTH_DEF-1:0]  id;
      logic [TIMEOUT_WIDTH-1:0] ticks;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty queue: tick, unknown code, zero timeout, remove of an absent id
      send_request(OP_TICK,   8'h00, 16'h0000);
      send_request(OP_UNUSED, 8'hFF, 16'hFFFF);
      send_request(OP_INSERT, 8'h00, 16'h0000);
      hold_off(2);
      send_request(OP_REMOVE, 8'hFF, 16'h0000);

      // widest timeout, then equal deadlines and a duplicate id
      send_request(OP_INSERT, 8'hFF, 16'hFFFF);
      send_request(OP_INSERT, 8'h00, 16'd1);
      send_request(OP_INSERT, 8'hAA, 16'd2);
      send_request(OP_INSERT, 8'h55, 16'd2);
      send_request(OP_INSERT, 8'h55, 16'd1);
      hold_off(1);
      // first 55 in deadline order goes; the tail entry goes too
      send_request(OP_REMOVE, 8'h55, 16'h0000);
      send_request(OP_REMOVE, 8'hFF, 16'h0000);
      // expire 00, then AA and 55 together
      send_request(OP_TICK,   8'h00, 16'h0000);
      send_request(OP_TICK,   8'h00, 16'h0000);

      // fill the queue with one common deadline, overflow it, expire all
      while (sb.fill < DEPTH_DEF)
         send_request(OP_INSERT, 8'h80 | ID_WIDTH_DEF'(sb.fill), 16'd1);
      send_request(OP_INSERT, 8'hC3, 16'd7);
      send_request(OP_TICK,   8'h00, 16'h0000);

      // Random bursts. Removes mostly target queued ids, ids sometimes come
      // from a small pool so duplicates show up, timeouts are mostly short so
      // entries expire, with the odd zero, wide or random one.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            roll  = $urandom_range(0, 99);
            id    = ($urandom_range(0, 3) == 0) ? ID_WIDTH_DEF'($urandom_range(0, 7))
                                                : ID_WIDTH_DEF'($urandom);
            ticks = TIMEOUT_WIDTH'($urandom);
            if (roll < 45) begin
               kind = OP_INSERT;
               case ($urandom_range(0, 19))
                  0:       ticks = '0;
                  1:       ticks = TIMEOUT_WIDTH'($urandom);
                  2:       ticks = '1;
                  default: ticks = TIMEOUT_WIDTH'($urandom_range(1, 16));
               endcase
            end else if (roll < 65) begin
               kind = OP_REMOVE;
               if ($urandom_range(0, 3) != 0)
                  id = sb.queued_id();
            end else if (roll < 97) begin
               kind = OP_TICK;
            end else begin
               kind = OP_UNUSED;
            end
            send_request(kind, id, ticks);
            if (!(kind == OP_UNUSED || (kind == OP_INSERT && ticks == 0)))
               counted++;
         end
         hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
      end

      // drain: wait out every expected result, then let the block settle
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests in random bursts against a stalling result side.",
               sb.requests);
      $display("Checked %0d results: %0d expiries, %0d full rejections, %0d mismatches.",
               sb.checked, sb.expiries, sb.rejections, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("timeout with %0d results still expected", sb.pending());
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
